// File: src/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

    localparam int HUE_W  = 15;
    localparam int FIX_W  = 18;
    localparam int BYTE_W = 8;
    localparam int FRAC_W = 16;
    localparam int HX_W   = 19;
    localparam int SEC_W  = 3;
    localparam int QUO_W  = 11;

    // 360 degrees in 1/64 degree steps
    localparam logic [HUE_W-1:0] HUE_FULL_CIRCLE = 15'd23040;

    // floor(h / 15) == (h * 69906) >> 20, exact for every 15-bit h
    localparam logic [16:0] RECIP15       = 17'd69906;
    localparam int          RECIP15_SHIFT = 20;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

    localparam logic [SEC_W-1:0] SECTOR_0 = 3'd0;
    localparam logic [SEC_W-1:0] SECTOR_1 = 3'd1;
    localparam logic [SEC_W-1:0] SECTOR_2 = 3'd2;
    localparam logic [SEC_W-1:0] SECTOR_3 = 3'd3;
    localparam logic [SEC_W-1:0] SECTOR_4 = 3'd4;

    // negative -> 0, one or more -> 255, else the top fraction byte
    function automatic logic [BYTE_W-1:0] clamp_to_byte(input logic signed [FIX_W-1:0] x);
        logic [BYTE_W-1:0] r;
        begin
            if (x[FIX_W-1])
            begin
                r = '0;
            end
            else if (x[FRAC_W])
            begin
                r = BYTE_MAX;
            end
            else
            begin
                r = x[FRAC_W-1:FRAC_W-BYTE_W];
            end
            return r;
        end
    endfunction

endpackage

// File: src/hsv_to_rgb_color.sv
// channel   | handshake             | payload
// ----------+-----------------------+-----------------------------------------
// source    | src_valid / src_stall | hue, saturation, brightness, alpha
// result    | rgb_valid / rgb_stall | red, green, blue, alpha_out
//
// six register stages, one item per cycle sustained while rgb_stall is low;
// each stage takes a new item when it is empty or its successor moves on, so
// a waiting result stalls only the stages that are full behind it
// rst_n clears the valid bits only; payload registers are not reset
// the stage multipliers (hue reciprocal, s * f, q/t scaling) set the depth
module hsv_to_rgb_color
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   src_valid,
    output logic                                   src_stall,
    input  logic        [hsv2rgb_pkg::HUE_W-1:0]   hue,
    input  logic signed [hsv2rgb_pkg::FIX_W-1:0]   saturation,
    input  logic signed [hsv2rgb_pkg::FIX_W-1:0]   brightness,
    input  logic        [hsv2rgb_pkg::BYTE_W-1:0]  alpha,

    output logic                                   rgb_valid,
    input  logic                                   rgb_stall,
    output logic        [hsv2rgb_pkg::BYTE_W-1:0]  red,
    output logic        [hsv2rgb_pkg::BYTE_W-1:0]  green,
    output logic        [hsv2rgb_pkg::BYTE_W-1:0]  blue,
    output logic        [hsv2rgb_pkg::BYTE_W-1:0]  alpha_out
);

    localparam int BW = hsv2rgb_pkg::BYTE_W;

    // per-stage valid bits and ready chain
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg, vld6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6 = !vld6_reg || !rgb_stall;
    assign rdy5 = !vld5_reg || rdy6;
    assign rdy4 = !vld4_reg || rdy5;
    assign rdy3 = !vld3_reg || rdy4;
    assign rdy2 = !vld2_reg || rdy3;
    assign rdy1 = !vld1_reg || rdy2;

    assign src_stall = !rdy1;
    assign rgb_valid = vld6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) vld1_reg <= src_valid;
            if (rdy2) vld2_reg <= vld1_reg;
            if (rdy3) vld3_reg <= vld2_reg;
            if (rdy4) vld4_reg <= vld3_reg;
            if (rdy5) vld5_reg <= vld4_reg;
            if (rdy6) vld6_reg <= vld5_reg;
        end
    end

    // stage 1: clamp saturation and value, fold hue of a full circle or more to zero
    logic [hsv2rgb_pkg::HUE_W-1:0] hue1_next, hue1_reg;
    logic [BW-1:0]                 s1_reg, v1_reg, a1_reg;

    assign hue1_next = (hue >= hsv2rgb_pkg::HUE_FULL_CIRCLE) ? '0 : hue;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            hue1_reg <= hue1_next;
            s1_reg   <= hsv2rgb_pkg::clamp_to_byte(saturation);
            v1_reg   <= hsv2rgb_pkg::clamp_to_byte(brightness);
            a1_reg   <= alpha;
        end
    end

    // stage 2: hue*256/15 = 17*hue + hue/15; hue/15 by reciprocal; p
    logic [31:0]                   quo_prod;
    logic [hsv2rgb_pkg::QUO_W-1:0] quo2_next, quo2_reg;
    logic [hsv2rgb_pkg::HX_W-1:0]  hue17_next, hue17_reg;
    logic [BW:0]                   vs1;
    logic [2*BW:0]                 p_prod;
    logic [BW-1:0]                 p2_reg, s2_reg, v2_reg, a2_reg;

    assign quo_prod   = 32'(hue1_reg) * 32'(hsv2rgb_pkg::RECIP15);
    assign quo2_next  = quo_prod[hsv2rgb_pkg::RECIP15_SHIFT +: hsv2rgb_pkg::QUO_W];
    assign hue17_next = {hue1_reg, 4'b0000} + hsv2rgb_pkg::HX_W'(hue1_reg);
    assign vs1        = {1'b0, v1_reg} + 9'd1;   // 1..256, never wraps
    assign p_prod     = (2*BW+1)'(hsv2rgb_pkg::BYTE_MAX - s1_reg) * (2*BW+1)'(vs1);

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            quo2_reg  <= quo2_next;
            hue17_reg <= hue17_next;
            p2_reg    <= p_prod[2*BW-1:BW];
            s2_reg    <= s1_reg;
            v2_reg    <= v1_reg;
            a2_reg    <= a1_reg;
        end
    end

    // stage 3: sector and fraction
    logic [hsv2rgb_pkg::HX_W-1:0]   hx_next;
    logic [hsv2rgb_pkg::FRAC_W-1:0] f3_reg;
    logic [hsv2rgb_pkg::SEC_W-1:0]  sec3_reg;
    logic [BW-1:0]                  p3_reg, s3_reg, v3_reg, a3_reg;

    assign hx_next = hue17_reg + hsv2rgb_pkg::HX_W'(quo2_reg);

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            f3_reg   <= hx_next[hsv2rgb_pkg::FRAC_W-1:0];
            sec3_reg <= hx_next[hsv2rgb_pkg::HX_W-1:hsv2rgb_pkg::FRAC_W];
            p3_reg   <= p2_reg;
            s3_reg   <= s2_reg;
            v3_reg   <= v2_reg;
            a3_reg   <= a2_reg;
        end
    end

    // stage 4: s*f and s*(1-f), top byte
    logic [hsv2rgb_pkg::FRAC_W:0]    f_inv;
    logic [BW+hsv2rgb_pkg::FRAC_W:0] sf_prod, sg_prod;
    logic [BW-1:0]                   sf4_reg, sg4_reg, p4_reg, s4_reg, v4_reg, a4_reg;
    logic [hsv2rgb_pkg::SEC_W-1:0]   sec4_reg;

    assign f_inv   = 17'h10000 - {1'b0, f3_reg};
    assign sf_prod = 25'(s3_reg) * 25'(f3_reg);
    assign sg_prod = 25'(s3_reg) * 25'(f_inv);

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            sf4_reg  <= sf_prod[hsv2rgb_pkg::FRAC_W +: BW];
            sg4_reg  <= sg_prod[hsv2rgb_pkg::FRAC_W +: BW];
            p4_reg   <= p3_reg;
            s4_reg   <= s3_reg;
            v4_reg   <= v3_reg;
            a4_reg   <= a3_reg;
            sec4_reg <= sec3_reg;
        end
    end

    // stage 5: q and t scaled by v+1
    logic [BW:0]                   vs4;
    logic [2*BW:0]                 q_prod, t_prod;
    logic [BW-1:0]                 q5_reg, t5_reg, p5_reg, v5_reg, a5_reg;
    logic                          gray5_reg;
    logic [hsv2rgb_pkg::SEC_W-1:0] sec5_reg;

    assign vs4    = {1'b0, v4_reg} + 9'd1;
    assign q_prod = (2*BW+1)'(hsv2rgb_pkg::BYTE_MAX - sf4_reg) * (2*BW+1)'(vs4);
    assign t_prod = (2*BW+1)'(hsv2rgb_pkg::BYTE_MAX - sg4_reg) * (2*BW+1)'(vs4);

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            q5_reg    <= q_prod[2*BW-1:BW];
            t5_reg    <= t_prod[2*BW-1:BW];
            p5_reg    <= p4_reg;
            v5_reg    <= v4_reg;
            a5_reg    <= a4_reg;
            gray5_reg <= (s4_reg == '0);
            sec5_reg  <= sec4_reg;
        end
    end

    // stage 6: sector select, gray override, output register
    logic [BW-1:0] red_next, green_next, blue_next;
    logic [BW-1:0] red_reg, green_reg, blue_reg, alpha_reg;

    always_comb
    begin
        red_next   = v5_reg;
        green_next = v5_reg;
        blue_next  = v5_reg;
        if (!gray5_reg)
        begin
            case (sec5_reg)
                hsv2rgb_pkg::SECTOR_0:
                begin
                    red_next = v5_reg; green_next = t5_reg; blue_next = p5_reg;
                end
                hsv2rgb_pkg::SECTOR_1:
                begin
                    red_next = q5_reg; green_next = v5_reg; blue_next = p5_reg;
                end
                hsv2rgb_pkg::SECTOR_2:
                begin
                    red_next = p5_reg; green_next = v5_reg; blue_next = t5_reg;
                end
                hsv2rgb_pkg::SECTOR_3:
                begin
                    red_next = p5_reg; green_next = q5_reg; blue_next = v5_reg;
                end
                hsv2rgb_pkg::SECTOR_4:
                begin
                    red_next = t5_reg; green_next = p5_reg; blue_next = v5_reg;
                end
                default:
                begin
                    red_next = v5_reg; green_next = p5_reg; blue_next = q5_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= a5_reg;
        end
    end

    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign alpha_out = alpha_reg;

endmodule

// File: src/hsv2rgb_checker.sv
module hsv2rgb_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   src_valid,
    input  logic                                   src_stall,
    input  logic signed [hsv2rgb_pkg::FIX_W-1:0]   saturation,
    input  logic signed [hsv2rgb_pkg::FIX_W-1:0]   brightness,
    input  logic        [hsv2rgb_pkg::BYTE_W-1:0]  alpha,
    input  logic                                   rgb_valid,
    input  logic                                   rgb_stall,
    input  logic        [hsv2rgb_pkg::BYTE_W-1:0]  red,
    input  logic        [hsv2rgb_pkg::BYTE_W-1:0]  green,
    input  logic        [hsv2rgb_pkg::BYTE_W-1:0]  blue,
    input  logic        [hsv2rgb_pkg::BYTE_W-1:0]  alpha_out
);

    logic       flow;
    logic       took;
    logic       through;
    logic [5:0] took_hist_reg;
    logic [4:0] flow_hist_reg;

    // output free to move and not in reset
    assign flow = rst_n && !rgb_stall;
    assign took = rst_n && src_valid && !src_stall;

    // acceptance and output freedom over the last edges
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            took_hist_reg <= '0;
            flow_hist_reg <= '0;
        end
        else
        begin
            took_hist_reg <= {took_hist_reg[4:0], took};
            flow_hist_reg <= {flow_hist_reg[3:0], flow};
        end
    end

    // item accepted at the oldest entry of the acceptance history with the result side free since then
    assign through = took_hist_reg[5] && (&flow_hist_reg);

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> rgb_valid)
        else $error("result valid dropped while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> $stable({red, green, blue, alpha_out}))
        else $error("stalled result changed");

    a_alpha_latency: assert property (@(posedge clk) disable iff (!rst_n)
        through |-> rgb_valid && (alpha_out == $past(alpha, 6)))
        else $error("item did not arrive after six free cycles with its alpha");

    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        through && ($past(saturation[hsv2rgb_pkg::FIX_W-1], 6)
                    || ($past(saturation[hsv2rgb_pkg::FIX_W-2:8], 6) == '0))
        |-> (red == green) && (green == blue))
        else $error("zero saturation did not give gray");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        through && $past(brightness[hsv2rgb_pkg::FIX_W-1], 6)
        |-> (red == '0) && (green == '0) && (blue == '0))
        else $error("negative value did not give black");

endmodule

bind hsv_to_rgb_color hsv2rgb_checker u_hsv2rgb_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .saturation (saturation),
    .brightness (brightness),
    .alpha      (alpha),
    .rgb_valid  (rgb_valid),
    .rgb_stall  (rgb_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha_out  (alpha_out)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps

// hsv to rgb conversion check: a queue of source colors feeds a clocked driver,
// a clocked monitor compares every result against a locally computed color

module testbench;

    typedef logic        [hsv2rgb_pkg::HUE_W-1:0]  hue_t;
    typedef logic signed [hsv2rgb_pkg::FIX_W-1:0]  fix_t;
    typedef logic        [hsv2rgb_pkg::BYTE_W-1:0] byte_t;
    typedef logic        [hsv2rgb_pkg::SEC_W-1:0]  sector_t;

    // one rgba result as the block should produce it
    typedef struct packed
    {
        byte_t red;
        byte_t green;
        byte_t blue;
        byte_t alpha;
    } rgba_t;

    // one source color plus the idle cycles to spend before offering it
    typedef struct packed
    {
        hue_t       hue;
        fix_t       sat;
        fix_t       val;
        byte_t      alpha;
        logic [7:0] gap;
        logic       drain;    // hold until every result is back
    } hsv_item_t;

    localparam int RANDOM_ITEMS = 800;
    localparam int SETTLE_CYCLES = 20;      // pipeline is six deep

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // source side, all driven from time zero
    logic  src_valid = 1'b0;
    logic  src_stall;
    hue_t  hue = '0;
    fix_t  saturation = '0;
    fix_t  brightness = '0;
    byte_t alpha = '0;

    // result side
    logic  rgb_valid;
    logic  rgb_stall = 1'b0;
    byte_t red;
    byte_t green;
    byte_t blue;
    byte_t alpha_out;

    // colors waiting to be offered and colors waiting to come back
    hsv_item_t source_colors[$];
    rgba_t     expected_colors[$];

    int        errors = 0;
    int        colors_received = 0;

    // driver bookkeeping
    hsv_item_t staged;
    bit        staged_loaded = 1'b0;
    int        gap_left = 0;
    bit        src_taken;

    // receiver bookkeeping
    int        stall_left = 0;
    int        stall_len;
    rgba_t     want;

    hsv_to_rgb_color DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .alpha      (alpha),
        .rgb_valid  (rgb_valid),
        .rgb_stall  (rgb_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha_out  (alpha_out)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // signed unit fraction to a byte: below zero is black, one or more is full
    function automatic int unsigned fraction_to_byte(input fix_t x);
        int unsigned b;
        begin
            if (x < 0)
            begin
                b = 0;
            end
            else if (x >= 18'sd65536)
            begin
                b = 32'(hsv2rgb_pkg::BYTE_MAX);
            end
            else
            begin
                b = 32'(x[15:8]);
            end
            return b;
        end
    endfunction

    // expected rgba for one source color
    function automatic rgba_t convert_hsv(input hue_t h, input fix_t s, input fix_t v,
                                          input byte_t a);
        rgba_t       c;
        int unsigned sb, vb, hh, hx, f, vs, p, q, t;
        sector_t     sector;
        begin
            sb = fraction_to_byte(s);
            vb = fraction_to_byte(v);
            c.alpha = a;
            if (sb == 0)
            begin
                // no saturation: plain gray at the value level
                c.red = byte_t'(vb);
                c.green = byte_t'(vb);
                c.blue = byte_t'(vb);
            end
            else
            begin
                // a hue at or past the full circle wraps to zero
                hh = (h >= hsv2rgb_pkg::HUE_FULL_CIRCLE) ? 0 : 32'(h);
                hx = (hh * 256) / 15;
                f = hx & 32'hFFFF;
                sector = sector_t'(hx >> 16);
                // value plus one stays nine bits wide at full value
                vs = vb + 1;
                p = ((255 - sb) * vs) >> 8;
                q = ((255 - ((sb * f) >> 16)) * vs) >> 8;
                t = ((255 - ((sb * (65536 - f)) >> 16)) * vs) >> 8;
                case (sector)
                    hsv2rgb_pkg::SECTOR_0:
                    begin
                        c.red = byte_t'(vb); c.green = byte_t'(t); c.blue = byte_t'(p);
                    end
                    hsv2rgb_pkg::SECTOR_1:
                    begin
                        c.red = byte_t'(q); c.green = byte_t'(vb); c.blue = byte_t'(p);
                    end
                    hsv2rgb_pkg::SECTOR_2:
                    begin
                        c.red = byte_t'(p); c.green = byte_t'(vb); c.blue = byte_t'(t);
                    end
                    hsv2rgb_pkg::SECTOR_3:
                    begin
                        c.red = byte_t'(p); c.green = byte_t'(q); c.blue = byte_t'(vb);
                    end
                    hsv2rgb_pkg::SECTOR_4:
                    begin
                        c.red = byte_t'(t); c.green = byte_t'(p); c.blue = byte_t'(vb);
                    end
                    default:
                    begin
                        c.red = byte_t'(vb); c.green = byte_t'(p); c.blue = byte_t'(q);
                    end
                endcase
            end
            return c;
        end
    endfunction

    // idle length: mostly none, some short, a few long; none at all when quiet
    function automatic int pick_idle(input bit quiet);
        int r;
        int n;
        begin
            r = $urandom_range(0, 99);
            if (quiet || r < 65)
            begin
                n = 0;
            end
            else if (r < 93)
            begin
                n = $urandom_range(1, 3);
            end
            else
            begin
                n = $urandom_range(10, 40);
            end
            return n;
        end
    endfunction

    // saturation or value: mostly inside the unit range, some outside it
    function automatic fix_t pick_fraction();
        int   r;
        fix_t x;
        begin
            r = $urandom_range(0, 9);
            if (r < 2)
            begin
                x = fix_t'($urandom);                       // any 18-bit pattern
            end
            else if (r < 8)
            begin
                x = fix_t'($urandom_range(0, 65535));
            end
            else if (r < 9)
            begin
                x = fix_t'($urandom_range(65280, 65791));   // around one
            end
            else
            begin
                x = -$signed({1'b0, 17'($urandom_range(1, 131071))});
            end
            return x;
        end
    endfunction

    task automatic queue_color(input int h, input int s, input int v, input int a,
                               input int gap, input bit drain);
        hsv_item_t it;
        begin
            it.hue = hue_t'(h);
            it.sat = fix_t'(s);
            it.val = fix_t'(v);
            it.alpha = byte_t'(a);
            it.gap = 8'(gap);
            it.drain = drain;
            source_colors.push_back(it);
        end
    endtask

    // stimulus, then the end of run once everything has come back
    initial
    begin
        int  h;
        bit  quiet;

        // directed: gray cases, every sector, hue wrap, clamp extremes
        queue_color(0, 0, 65535, 0, 0, 1'b0);
        queue_color(12345, 255, 32768, 255, 0, 1'b0);           // saturation byte zero
        queue_color(1920, -1, 131071, 17, 1, 1'b0);             // negative saturation
        for (int k = 0; k < 6; k++)
        begin
            queue_color(1920 + 3840 * k, 49152, 65535, 40 * k, 0, 1'b0);
        end
        queue_color(3839, 65535, 65536, 200, 0, 1'b0);          // full value byte
        queue_color(3840, 65535, 65536, 201, 0, 1'b0);          // sector boundary
        queue_color(23039, 65535, 65535, 202, 0, 1'b0);         // last valid hue
        queue_color(23040, 65535, 65535, 203, 2, 1'b0);         // full circle wraps
        queue_color(32767, 65535, 65535, 204, 0, 1'b0);         // largest hue
        queue_color(5000, -131072, 40000, 205, 0, 1'b0);
        queue_color(9000, 65536, -131072, 206, 0, 1'b0);
        queue_color(13000, 131071, 65535, 207, 0, 1'b0);
        queue_color(17000, 256, 256, 208, 0, 1'b0);
        queue_color(19200, 65536, 65536, 209, 0, 1'b0);
        queue_color(21000, 65535, -1, 210, 0, 1'b0);
        queue_color(7680, 100000, 100000, 211, 0, 1'b0);

        // random colors; every fourth stretch of a hundred runs without gaps
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet = ((i / 100) % 4) == 1;
            if ($urandom_range(0, 3) == 0)
            begin
                h = $urandom_range(0, 32767);
            end
            else
            begin
                h = $urandom_range(0, 23039);
            end
            queue_color(h, pick_fraction(), pick_fraction(), $urandom_range(0, 255),
                        pick_idle(quiet), i == 0 || i == 400);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the source queue and the expected store to run dry,
        // sampled away from the active edge so driven values have settled
        while (source_colors.size() != 0 || staged_loaded || src_valid
               || expected_colors.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("testbench: errors");
        $finish;
    end

    // driver: offers staged colors, records the expected result on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            staged_loaded = 1'b0;
            gap_left = 0;
        end
        else
        begin
            src_taken = src_valid && !src_stall;
            if (src_taken)
            begin
                expected_colors.push_back(convert_hsv(hue, saturation, brightness, alpha));
            end
            // a stalled item holds valid and payload as they are
            if (!src_valid || src_taken)
            begin
                if (!staged_loaded && source_colors.size() != 0)
                begin
                    staged = source_colors.pop_front();
                    staged_loaded = 1'b1;
                    gap_left = staged.gap;
                end
                if (staged_loaded && gap_left == 0
                    && (!staged.drain || expected_colors.size() == 0))
                begin
                    src_valid <= 1'b1;
                    hue <= staged.hue;
                    saturation <= staged.sat;
                    brightness <= staged.val;
                    alpha <= staged.alpha;
                    staged_loaded = 1'b0;
                end
                else
                begin
                    src_valid <= 1'b0;
                    if (staged_loaded && gap_left > 0)
                    begin
                        gap_left--;
                    end
                end
            end
        end
    end

    // monitor: checks each accepted result, then picks the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rgb_valid && !rgb_stall)
            begin
                colors_received++;
                if (expected_colors.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected result r=%0d g=%0d b=%0d a=%0d",
                                 red, green, blue, alpha_out);
                    end
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (red !== want.red || green !== want.green
                        || blue !== want.blue || alpha_out !== want.alpha)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display({"mismatch: expected r=%0d g=%0d b=%0d a=%0d, ",
                                      "got r=%0d g=%0d b=%0d a=%0d"},
                                     want.red, want.green, want.blue, want.alpha,
                                     red, green, blue, alpha_out);
                        end
                    end
                end
            end
            // a stretch of results with no back pressure now and then
            if (stall_left > 0)
            begin
                stall_left--;
                rgb_stall <= 1'b1;
            end
            else
            begin
                stall_len = pick_idle(((colors_received / 100) % 4) == 2);
                if (stall_len > 0)
                begin
                    stall_left = stall_len - 1;
                    rgb_stall <= 1'b1;
                end
                else
                begin
                    rgb_stall <= 1'b0;
                end
            end
        end
    end

endmodule
